FILE: rtl/core/rop_pkg.sv
package rop_pkg;

   localparam int OVERLAY_WORDS = 16384;
   localparam int ADDR_W        = $clog2(OVERLAY_WORDS);

   localparam int REQ_DATA_W = 112;
   localparam int REQ_USER_W = 3;
   localparam int RSP_DATA_W = 80;
   localparam int CSR_ADDR_W = 2;
   localparam int CSR_DATA_W = 16;

   typedef enum logic [1:0] {
      CMD_PIXEL  = 2'd0,
      CMD_WINDOW = 2'd1,
      CMD_STORE  = 2'd2
   } cmd_type;

   typedef enum logic [CSR_ADDR_W-1:0] {
      CSR_OVL_LEFT = 2'd0,
      CSR_OVL_TOP  = 2'd1,
      CSR_OVL_COLS = 2'd2,
      CSR_OVL_ROWS = 2'd3
   } csr_idx_type;

   typedef enum logic {
      KIND_PIXEL  = 1'b0,
      KIND_WINDOW = 1'b1
   } kind_type;

   typedef struct packed {
      logic [15:0] left;
      logic [15:0] top;
      logic [7:0]  cols;
      logic [7:0]  rows;
   } ovl_cfg_type;

   // one transaction after the scan stage
   typedef struct packed {
      cmd_type     cmd;
      logic [15:0] pixel;
      logic        in_area;
      logic [15:0] abs_x;
      logic [15:0] abs_y;
      logic [15:0] win_left;
      logic [15:0] win_top;
      logic [15:0] win_cols;
      logic [15:0] win_rows;
      logic [13:0] store_addr;
      logic [15:0] store_data;
   } scan_item_type;

endpackage

FILE: rtl/core/rect_overlay_pixel_compositor_unit.sv
// channel   direction  handshake               payload
// req       in         req_tvalid/req_tready   tdata: pixel, window, store; tuser: command, start
// rsp       out        rsp_tvalid/rsp_tready   tdata: pixel, forwarded window; tuser: kind
// csr       in         csr_valid/csr_ready     csr_addr register index, csr_wdata value
//
// one transaction per clock while rsp is not stalled; a request is registered in stage one,
// then its result in stage two; stage one updates the scan position, stage two computes the
// overlay address and reads the store, whose registered read data is selected onto rsp_tdata
// store writes and commands that give no result leave a bubble in the result stream
// synchronous reset clears the window, scan position, overlay registers and valids;
// the overlay store is not cleared
// a stall on rsp holds every stage; req_tready drops only while both stages are full
// and rsp is stalled
module rect_overlay_pixel_compositor_unit (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_tvalid,
   output logic                           req_tready,
   // pixel_in, window_left, window_top, window_cols, window_rows, store_addr,
   // store_data, zero fill
   input  logic [rop_pkg::REQ_DATA_W-1:0] req_tdata,
   // command, push_start
   input  logic [rop_pkg::REQ_USER_W-1:0] req_tuser,
   output logic                           rsp_tvalid,
   input  logic                           rsp_tready,
   // pixel_out, fwd_left, fwd_top, fwd_cols, fwd_rows
   output logic [rop_pkg::RSP_DATA_W-1:0] rsp_tdata,
   // kind
   output logic                           rsp_tuser,
   input  logic                           csr_valid,
   output logic                           csr_ready,
   input  logic [rop_pkg::CSR_ADDR_W-1:0] csr_addr,
   input  logic [rop_pkg::CSR_DATA_W-1:0] csr_wdata
);
   import rop_pkg::*;

   ovl_cfg_type   cfg_ff, cfg_in;
   logic          item_valid;
   logic          item_take;
   scan_item_type item;

   assign csr_ready = 1'b1;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         case (csr_idx_type'(csr_addr))
            CSR_OVL_LEFT: cfg_in.left = csr_wdata;
            CSR_OVL_TOP:  cfg_in.top  = csr_wdata;
            CSR_OVL_COLS: cfg_in.cols = csr_wdata[7:0];
            CSR_OVL_ROWS: cfg_in.rows = csr_wdata[7:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   rop_scan u_scan (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .item_take  (item_take),
      .item_valid (item_valid),
      .item       (item)
   );

   rop_composite u_comp (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg_ff),
      .item_valid (item_valid),
      .item       (item),
      .item_take  (item_take),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

endmodule

FILE: rtl/core/rop_scan.sv
module rop_scan (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_tvalid,
   output logic                              req_tready,
   input  logic [rop_pkg::REQ_DATA_W-1:0]    req_tdata,
   input  logic [rop_pkg::REQ_USER_W-1:0]    req_tuser,
   input  logic                              item_take,
   output logic                              item_valid,
   output rop_pkg::scan_item_type            item
);
   import rop_pkg::*;

   logic [15:0] win_left_ff, win_left_in;
   logic [15:0] win_top_ff, win_top_in;
   logic [15:0] win_cols_ff, win_cols_in;
   logic [15:0] win_rows_ff, win_rows_in;
   logic [15:0] col_ff, col_in;
   logic [16:0] row_ff, row_in;
   logic        valid_ff, valid_in;
   scan_item_type item_ff, item_in;

   logic        accept;
   cmd_type     cmd;
   logic        start;
   logic [15:0] col_cur;
   logic [16:0] row_cur;
   logic [16:0] col_next;
   logic        in_area;

   assign req_tready = !valid_ff || item_take;
   assign accept     = req_tvalid && req_tready;
   assign cmd        = cmd_type'(req_tuser[1:0]);
   assign start      = req_tuser[2];

   assign col_cur  = start ? 16'd0 : col_ff;
   assign row_cur  = start ? 17'd0 : row_ff;
   assign in_area  = (win_cols_ff != 16'd0) && (row_cur < {1'b0, win_rows_ff});
   assign col_next = {1'b0, col_cur} + 17'd1;

   always_comb begin
      win_left_in = win_left_ff;
      win_top_in  = win_top_ff;
      win_cols_in = win_cols_ff;
      win_rows_in = win_rows_ff;
      col_in      = col_ff;
      row_in      = row_ff;
      if (accept) begin
         case (cmd)
            CMD_PIXEL: begin
               col_in = col_cur;
               row_in = row_cur;
               if (in_area) begin
                  if (col_next >= {1'b0, win_cols_ff}) begin
                     col_in = 16'd0;
                     row_in = row_cur + 17'd1;
                  end else begin
                     col_in = col_next[15:0];
                  end
               end
            end
            CMD_WINDOW: begin
               win_left_in = req_tdata[31:16];
               win_top_in  = req_tdata[47:32];
               win_cols_in = req_tdata[63:48];
               win_rows_in = req_tdata[79:64];
               col_in      = 16'd0;
               row_in      = 17'd0;
            end
            default: ;
         endcase
      end
   end

   always_comb begin
      valid_in = valid_ff;
      item_in  = item_ff;
      if (req_tready) begin
         valid_in           = req_tvalid;
         item_in.cmd        = cmd;
         item_in.pixel      = req_tdata[15:0];
         item_in.in_area    = in_area;
         item_in.abs_x      = win_left_ff + col_cur;
         item_in.abs_y      = win_top_ff + row_cur[15:0];
         item_in.win_left   = req_tdata[31:16];
         item_in.win_top    = req_tdata[47:32];
         item_in.win_cols   = req_tdata[63:48];
         item_in.win_rows   = req_tdata[79:64];
         item_in.store_addr = req_tdata[93:80];
         item_in.store_data = req_tdata[109:94];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         win_left_ff <= '0;
         win_top_ff  <= '0;
         win_cols_ff <= '0;
         win_rows_ff <= '0;
         col_ff      <= '0;
         row_ff      <= '0;
         valid_ff    <= 1'b0;
      end else begin
         win_left_ff <= win_left_in;
         win_top_ff  <= win_top_in;
         win_cols_ff <= win_cols_in;
         win_rows_ff <= win_rows_in;
         col_ff      <= col_in;
         row_ff      <= row_in;
         valid_ff    <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      item_ff <= item_in;
   end

   assign item_valid = valid_ff;
   assign item       = item_ff;

endmodule

FILE: rtl/core/rop_ram.sv
module rop_ram #(
   parameter int DEPTH  = 16384,
   parameter int DATA_W = 16,
   parameter int ADDR_W = $clog2(DEPTH)
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [DATA_W-1:0] wr_data,
   input  logic              rd_en,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [DATA_W-1:0] rd_data
);

   logic [DATA_W-1:0] mem [DEPTH];
   logic [DATA_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: rtl/core/rop_composite.sv
module rop_composite (
   input  logic                           clock,
   input  logic                           reset,
   input  rop_pkg::ovl_cfg_type           cfg,
   input  logic                           item_valid,
   input  rop_pkg::scan_item_type         item,
   output logic                           item_take,
   output logic                           rsp_tvalid,
   input  logic                           rsp_tready,
   output logic [rop_pkg::RSP_DATA_W-1:0] rsp_tdata,
   output logic                           rsp_tuser
);
   import rop_pkg::*;

   logic              valid_ff, valid_in;
   kind_type          kind_ff, kind_in;
   logic              use_ovl_ff, use_ovl_in;
   logic [15:0]       pixel_ff, pixel_in;
   logic [63:0]       fwd_ff, fwd_in;

   logic [16:0]       x_end;
   logic [16:0]       y_end;
   logic              hit;
   logic [15:0]       ox;
   logic [15:0]       oy;
   logic [23:0]       prod;
   logic [23:0]       lin;
   logic [ADDR_W-1:0] rd_addr;
   logic              step;
   logic              wr_en;
   logic [15:0]       ovl_word;

   assign item_take = !valid_ff || rsp_tready;
   assign step      = item_valid && item_take;

   assign x_end  = {1'b0, cfg.left} + {9'd0, cfg.cols};
   assign y_end  = {1'b0, cfg.top} + {9'd0, cfg.rows};
   assign hit    = (item.abs_x >= cfg.left) && ({1'b0, item.abs_x} < x_end) &&
                   (item.abs_y >= cfg.top) && ({1'b0, item.abs_y} < y_end);
   assign ox      = item.abs_x - cfg.left;
   assign oy      = item.abs_y - cfg.top;
   assign prod    = {8'd0, oy} * {16'd0, cfg.cols};
   assign lin     = prod + {8'd0, ox};
   assign rd_addr = lin[ADDR_W-1:0];
   assign wr_en   = step && (item.cmd == CMD_STORE);

   rop_ram #(
      .DEPTH  (OVERLAY_WORDS),
      .DATA_W (16)
   ) u_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (ADDR_W'(item.store_addr)),
      .wr_data (item.store_data),
      .rd_en   (step),
      .rd_addr (rd_addr),
      .rd_data (ovl_word)
   );

   always_comb begin
      valid_in   = valid_ff;
      kind_in    = kind_ff;
      use_ovl_in = use_ovl_ff;
      pixel_in   = pixel_ff;
      fwd_in     = fwd_ff;
      if (item_take) begin
         valid_in   = 1'b0;
         kind_in    = KIND_PIXEL;
         use_ovl_in = 1'b0;
         pixel_in   = item.pixel;
         fwd_in     = '0;
         if (item_valid) begin
            case (item.cmd)
               CMD_PIXEL: begin
                  valid_in   = 1'b1;
                  use_ovl_in = item.in_area && hit;
               end
               CMD_WINDOW: begin
                  valid_in = 1'b1;
                  kind_in  = KIND_WINDOW;
                  pixel_in = '0;
                  fwd_in   = {item.win_rows, item.win_cols, item.win_top, item.win_left};
               end
               default: ;
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      kind_ff    <= kind_in;
      use_ovl_ff <= use_ovl_in;
      pixel_ff   <= pixel_in;
      fwd_ff     <= fwd_in;
   end

   assign rsp_tvalid = valid_ff;
   assign rsp_tuser  = kind_ff;
   assign rsp_tdata  = {fwd_ff, use_ovl_ff ? ovl_word : pixel_ff};

endmodule

FILE: rtl/core/rop_checker.sv
module rop_checker (
   input logic                           clock,
   input logic                           reset,
   input logic                           rsp_tvalid,
   input logic                           rsp_tready,
   input logic [rop_pkg::RSP_DATA_W-1:0] rsp_tdata,
   input logic                           rsp_tuser
);
   import rop_pkg::*;

   // a waiting transaction is not withdrawn
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid)
      else $error("rsp transaction dropped while stalled");

   a_window_zero_pixel: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && (rsp_tuser == KIND_WINDOW) |-> rsp_tdata[15:0] == 16'd0)
      else $error("window result carries a pixel");

   a_pixel_zero_fwd: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && (rsp_tuser == KIND_PIXEL) |-> rsp_tdata[79:16] == 64'd0)
      else $error("pixel result carries window fields");

   a_reset_idle: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("result pending after reset");

endmodule

bind rect_overlay_pixel_compositor_unit rop_checker u_rop_checker (
   .clock      (clock),
   .reset      (reset),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser)
);

FILE: tb/rect_overlay_pixel_compositor_unit_tb.sv
`timescale 1ns / 1ps

module rect_overlay_pixel_compositor_unit_tb;
   import rop_pkg::*;

   localparam logic [1:0] CMD_UNUSED   = 2'd3;
   localparam int WATCHDOG_LIMIT        = 4000;
   localparam int PIPE_FLUSH            = 4;
   localparam int LONG_HOLD             = 200;
   localparam int PHASES                = 8;
   localparam int PHASE_ITEMS           = 250;

   typedef struct {
      logic [1:0]  cmd;
      logic        start;
      logic [15:0] pix;
      logic [15:0] wl, wt, wc, wr;
      logic [13:0] addr;
      logic [15:0] sdata;
   } req_item_type;

   typedef struct {
      kind_type    kind;
      logic [15:0] pix, left, top, cols, rows;
   } rsp_item_type;

   typedef struct {
      bit           is_csr;
      csr_idx_type  reg_idx;
      logic [15:0]  reg_val;
      req_item_type it;
      bit           typed;
      logic [15:0]  typed_pix;
   } plan_row_type;

   logic                  clock;
   logic                  reset;
   logic                  req_tvalid;
   logic                  req_tready;
   logic [REQ_DATA_W-1:0] req_tdata;
   logic [REQ_USER_W-1:0] req_tuser;
   logic                  rsp_tvalid;
   logic                  rsp_tready;
   logic [RSP_DATA_W-1:0] rsp_tdata;
   logic                  rsp_tuser;
   logic                  csr_valid;
   logic                  csr_ready;
   logic [CSR_ADDR_W-1:0] csr_addr;
   logic [CSR_DATA_W-1:0] csr_wdata;

   // predictor state
   logic [15:0] ovl_left, ovl_top;
   logic [7:0]  ovl_cols, ovl_rows;
   logic [15:0] w_left, w_top, w_cols, w_rows;
   logic [15:0] col_pos;
   logic [16:0] row_pos;
   logic [15:0] overlay_words [OVERLAY_WORDS];
   bit          word_written [OVERLAY_WORDS];

   rsp_item_type awaited_out [$];
   rsp_item_type result_due;
   plan_row_type plan [$];

   int error_count, sent_count, store_count, result_count, setting_count;
   int send_idle_pct, rsp_stall_pct;
   int hold_tok, hold_seen, hold_left;
   int quiet_cycles;

   rect_overlay_pixel_compositor_unit DUT (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_addr   (csr_addr),
      .csr_wdata  (csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   task automatic report_mismatch(input string what, input logic [15:0] got,
                                  input logic [15:0] want);
      $display("%0t mismatch on %s: got %h, expected %h", $realtime, what, got, want);
      error_count++;
   endtask

   // overlay store index the next pixel would read, if it lands inside the overlay
   function automatic bit overlay_index(input bit restart, output int idx);
      int c, r, ax, ay;
      c = restart ? 0 : int'(col_pos);
      r = restart ? 0 : int'(row_pos);
      idx = 0;
      if (w_cols == 16'd0 || r >= int'(w_rows)) return 1'b0;
      ax = (int'(w_left) + c) & 'hFFFF;
      ay = (int'(w_top) + r) & 'hFFFF;
      // upper bounds do not wrap
      if (ax < int'(ovl_left) || ax >= int'(ovl_left) + int'(ovl_cols)) return 1'b0;
      if (ay < int'(ovl_top) || ay >= int'(ovl_top) + int'(ovl_rows)) return 1'b0;
      idx = ((ay - int'(ovl_top)) * int'(ovl_cols) + ax - int'(ovl_left)) % OVERLAY_WORDS;
      return 1'b1;
   endfunction

   function automatic bit advance_compositor(input req_item_type it,
                                             output rsp_item_type r);
      int idx;
      r = '{KIND_PIXEL, 16'h0, 16'h0, 16'h0, 16'h0, 16'h0};
      case (it.cmd)
         CMD_PIXEL: begin
            if (it.start) begin
               col_pos = '0;
               row_pos = '0;
            end
            r.pix = it.pix;
            if (w_cols != 16'd0 && row_pos < w_rows) begin
               if (overlay_index(1'b0, idx)) r.pix = overlay_words[idx];
               col_pos = col_pos + 16'd1;
               if (col_pos >= w_cols) begin
                  col_pos = '0;
                  row_pos = row_pos + 17'd1;
               end
            end
            return 1'b1;
         end
         CMD_WINDOW: begin
            w_left  = it.wl;
            w_top   = it.wt;
            w_cols  = it.wc;
            w_rows  = it.wr;
            col_pos = '0;
            row_pos = '0;
            r = '{KIND_WINDOW, 16'h0, it.wl, it.wt, it.wc, it.wr};
            return 1'b1;
         end
         CMD_STORE: begin
            overlay_words[it.addr] = it.sdata;
            word_written[it.addr]  = 1'b1;
         end
         default: ;
      endcase
      return 1'b0;
   endfunction

   function automatic req_item_type mk_pixel(input logic [15:0] pix, input logic start);
      req_item_type it;
      it = '{default: '0};
      it.cmd   = CMD_PIXEL;
      it.pix   = pix;
      it.start = start;
      return it;
   endfunction

   function automatic req_item_type mk_window(input logic [15:0] l, t, c, r);
      req_item_type it;
      it = '{default: '0};
      it.cmd = CMD_WINDOW;
      it.wl  = l;
      it.wt  = t;
      it.wc  = c;
      it.wr  = r;
      return it;
   endfunction

   function automatic req_item_type mk_store(input logic [13:0] a, input logic [15:0] d);
      req_item_type it;
      it = '{default: '0};
      it.cmd   = CMD_STORE;
      it.addr  = a;
      it.sdata = d;
      return it;
   endfunction

   // unused command with random payload, must vanish without trace
   function automatic req_item_type mk_noise();
      req_item_type it;
      it.cmd   = CMD_UNUSED;
      it.start = 1'($urandom);
      it.pix   = 16'($urandom);
      it.wl    = 16'($urandom);
      it.wt    = 16'($urandom);
      it.wc    = 16'($urandom);
      it.wr    = 16'($urandom);
      it.addr  = 14'($urandom);
      it.sdata = 16'($urandom);
      return it;
   endfunction

   function automatic plan_row_type req_row(input req_item_type it, input bit typed = 1'b0,
                                            input logic [15:0] typed_pix = '0);
      plan_row_type p;
      p.is_csr    = 1'b0;
      p.reg_idx   = CSR_OVL_LEFT;
      p.reg_val   = '0;
      p.it        = it;
      p.typed     = typed;
      p.typed_pix = typed_pix;
      return p;
   endfunction

   function automatic plan_row_type csr_row(input csr_idx_type idx, input logic [15:0] val);
      plan_row_type p;
      p.is_csr    = 1'b1;
      p.reg_idx   = idx;
      p.reg_val   = val;
      p.it        = '{default: '0};
      p.typed     = 1'b0;
      p.typed_pix = '0;
      return p;
   endfunction

   // one request transaction, random gap first
   task automatic offer(input req_item_type it, output bit gives,
                        output rsp_item_type want);
      while ($urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {2'b00, it.sdata, it.addr, it.wr, it.wc, it.wt, it.wl, it.pix};
      req_tuser  <= {it.start, it.cmd};
      do @(posedge clock); while (!req_tready);
      gives = advance_compositor(it, want);
      sent_count++;
      if (it.cmd == CMD_STORE) store_count++;
   endtask

   task automatic send(input req_item_type it, input bit typed = 1'b0,
                       input logic [15:0] typed_pix = '0);
      int           idx;
      bit           gives;
      rsp_item_type want;
      // never let a pixel read an overlay word that has not been written yet
      if (it.cmd == CMD_PIXEL && overlay_index(it.start, idx) && !word_written[idx])
         offer(mk_store(14'(idx), 16'($urandom)), gives, want);
      offer(it, gives, want);
      if (gives) begin
         if (typed && it.cmd == CMD_WINDOW)
            want = '{KIND_WINDOW, 16'h0, it.wl, it.wt, it.wc, it.wr};
         else if (typed)
            want = '{KIND_PIXEL, typed_pix, 16'h0, 16'h0, 16'h0, 16'h0};
         awaited_out.push_back(want);
      end
   endtask

   // caller lowers csr_valid after the last write of a group
   task automatic write_csr(input csr_idx_type idx, input logic [15:0] val);
      csr_valid <= 1'b1;
      csr_addr  <= idx;
      csr_wdata <= val;
      do @(posedge clock); while (!csr_ready);
      case (idx)
         CSR_OVL_LEFT: ovl_left = val;
         CSR_OVL_TOP:  ovl_top  = val;
         CSR_OVL_COLS: ovl_cols = val[7:0];
         CSR_OVL_ROWS: ovl_rows = val[7:0];
         default: ;
      endcase
   endtask

   // stores and dropped commands leave nothing to wait for, so keep flushing after the queue drains
   task automatic wait_idle();
      req_tvalid <= 1'b0;
      while (awaited_out.size() != 0) @(posedge clock);
      repeat (PIPE_FLUSH) @(posedge clock);
   endtask

   task automatic run_burst(inout int done);
      int           pick, n;
      req_item_type w;
      pick = $urandom_range(99);
      if (pick < 80) begin
         // small window placed around the overlay so the scan crosses its edges
         w = mk_window(16'(int'(ovl_left) + int'($urandom_range(0, int'(ovl_cols) + 10)) - 10),
                       16'(int'(ovl_top) + int'($urandom_range(0, int'(ovl_rows) + 10)) - 10),
                       16'($urandom_range(1, 24)), 16'($urandom_range(1, 12)));
         n = int'(w.wc) * int'(w.wr) + int'($urandom_range(0, 3));
      end else if (pick < 90) begin
         w = mk_window(16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom));
         n = $urandom_range(0, 20);
      end else if (pick < 96) begin
         send(mk_store(14'($urandom), 16'($urandom)));
         done++;
         return;
      end else begin
         send(mk_noise());
         return;
      end
      send(w);
      done++;
      repeat (n) begin
         pick = $urandom_range(99);
         if (pick < 4) begin
            send(mk_store(14'($urandom), 16'($urandom)));
            done++;
         end else if (pick < 5) begin
            send(mk_noise());
         end else begin
            send(mk_pixel(16'($urandom), pick >= 95));
            done++;
         end
      end
   endtask

   // result side: random stall, plus a long hold-off on request
   always @(posedge clock) begin
      if (hold_tok != hold_seen) begin
         hold_seen = hold_tok;
         hold_left = LONG_HOLD;
      end
      if (hold_left > 0) begin
         hold_left--;
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= ($urandom_range(99) >= rsp_stall_pct);
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) begin
         result_count++;
         if (awaited_out.size() == 0) begin
            report_mismatch("unexpected result", rsp_tdata[15:0], 16'h0);
         end else begin
            result_due = awaited_out.pop_front();
            if (rsp_tuser !== result_due.kind)
               report_mismatch("kind", 16'(rsp_tuser), 16'(result_due.kind));
            if (rsp_tdata[15:0] !== result_due.pix)
               report_mismatch("pixel_out", rsp_tdata[15:0], result_due.pix);
            if (rsp_tdata[31:16] !== result_due.left)
               report_mismatch("fwd_left", rsp_tdata[31:16], result_due.left);
            if (rsp_tdata[47:32] !== result_due.top)
               report_mismatch("fwd_top", rsp_tdata[47:32], result_due.top);
            if (rsp_tdata[63:48] !== result_due.cols)
               report_mismatch("fwd_cols", rsp_tdata[63:48], result_due.cols);
            if (rsp_tdata[79:64] !== result_due.rows)
               report_mismatch("fwd_rows", rsp_tdata[79:64], result_due.rows);
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) ||
          (csr_valid && csr_ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("%0t watchdog: no transaction for %0d cycles", $realtime, WATCHDOG_LIMIT);
         $display("Testbench completed WITH ERRORS");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   initial begin
      int          done;
      bit          held, paused;
      logic [15:0] c_left, c_top, c_cols, c_rows;

      reset      = 1'b1;
      req_tvalid = 1'b0;
      req_tdata  = '0;
      req_tuser  = '0;
      rsp_tready = 1'b0;
      csr_valid  = 1'b0;
      csr_addr   = CSR_OVL_LEFT;
      csr_wdata  = '0;
      ovl_left = '0; ovl_top = '0; ovl_cols = '0; ovl_rows = '0;
      w_left = '0; w_top = '0; w_cols = '0; w_rows = '0;
      col_pos = '0; row_pos = '0;
      send_idle_pct = 0;
      rsp_stall_pct = 0;

      // directed: reset state, field extremes, then a window that wraps in x and y
      plan.push_back(req_row(mk_pixel(16'hFFFF, 1'b1), 1'b1, 16'hFFFF));
      plan.push_back(req_row(mk_pixel(16'h0000, 1'b0), 1'b1, 16'h0000));
      plan.push_back(req_row(mk_window(16'h0, 16'h0, 16'h0, 16'h0), 1'b1));
      plan.push_back(req_row(mk_noise()));
      plan.push_back(req_row(mk_window(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF), 1'b1));
      plan.push_back(req_row(mk_pixel(16'h1234, 1'b0), 1'b1, 16'h1234));
      plan.push_back(csr_row(CSR_OVL_LEFT, 16'hFFFC));
      plan.push_back(csr_row(CSR_OVL_TOP, 16'h0000));
      plan.push_back(csr_row(CSR_OVL_COLS, 16'd8));
      plan.push_back(csr_row(CSR_OVL_ROWS, 16'd2));
      plan.push_back(req_row(mk_store(14'h3FFF, 16'hFFFF)));
      plan.push_back(req_row(mk_store(14'h0000, 16'h0000)));
      plan.push_back(req_row(mk_window(16'hFFFE, 16'hFFFF, 16'd4, 16'd2), 1'b1));
      repeat (8) plan.push_back(req_row(mk_pixel(16'($urandom), 1'b0)));
      // scan finished, pixel passes untouched
      plan.push_back(req_row(mk_pixel(16'hA5A5, 1'b0), 1'b1, 16'hA5A5));
      plan.push_back(req_row(mk_pixel(16'($urandom), 1'b1)));

      repeat (4) @(posedge clock);
      reset <= 1'b0;

      foreach (plan[i]) begin
         if (plan[i].is_csr) begin
            if (i == 0 || !plan[i-1].is_csr) wait_idle();
            write_csr(plan[i].reg_idx, plan[i].reg_val);
         end else begin
            if (i > 0 && plan[i-1].is_csr) csr_valid <= 1'b0;
            send(plan[i].it, plan[i].typed, plan[i].typed_pix);
         end
      end
      setting_count = 1;

      for (int ph = 0; ph < PHASES; ph++) begin
         wait_idle();
         case (ph % 4)
            0: begin send_idle_pct = 0;  rsp_stall_pct = 0;  end
            1: begin send_idle_pct = 75; rsp_stall_pct = 0;  end
            2: begin send_idle_pct = 0;  rsp_stall_pct = 75; end
            default: begin send_idle_pct = 30; rsp_stall_pct = 30; end
         endcase
         c_left = 16'($urandom);
         c_top  = 16'($urandom);
         c_cols = 16'($urandom_range(1, 128));
         c_rows = 16'($urandom_range(1, 128));
         case (ph)
            0: begin c_left = 16'h0; c_top = 16'h0; c_cols = 16'd128; c_rows = 16'd128; end
            1: begin c_left = 16'hFFFF; c_top = 16'hFFFF; c_cols = 16'd1; c_rows = 16'd1; end
            2: c_cols = 16'd0;
            3: c_rows = 16'd0;
            default: ;
         endcase
         write_csr(CSR_OVL_LEFT, c_left);
         write_csr(CSR_OVL_TOP, c_top);
         write_csr(CSR_OVL_COLS, c_cols);
         write_csr(CSR_OVL_ROWS, c_rows);
         csr_valid <= 1'b0;
         setting_count++;

         done   = 0;
         held   = 1'b0;
         paused = 1'b0;
         while (done < PHASE_ITEMS) begin
            // long back-pressure while the sender keeps offering
            if (ph == 4 && !held && done >= 100) begin
               hold_tok <= hold_tok + 1;
               held = 1'b1;
            end
            if (ph == 5 && !paused && done >= 120) begin
               wait_idle();
               paused = 1'b1;
            end
            run_burst(done);
         end
      end

      wait_idle();
      $display("%0d request transactions (%0d overlay store writes), %0d results checked",
               sent_count, store_count, result_count);
      $display("%0d overlay settings, with long result hold-off and a mid-stream drain",
               setting_count);
      if (error_count == 0)
         $display("Testbench completed without errors");
      else
         $display("Testbench completed WITH ERRORS");
      $finish;
   end

endmodule

FILE: files.f
rtl/core/rop_pkg.sv
rtl/core/rop_scan.sv
rtl/core/rop_ram.sv
rtl/core/rop_composite.sv
rtl/core/rect_overlay_pixel_compositor_unit.sv
rtl/core/rop_checker.sv
tb/rect_overlay_pixel_compositor_unit_tb.sv
